FILE: sv/bpq_pkg.sv
// Shared types and constants of the bucket priority queue.
// Depends on nothing; bpq_key and the queue unit use it by scoped names.
package bpq_pkg;

   // Fixed field widths of the request and response beats.
   localparam int ID_W      = 12;
   localparam int COUNT_W   = 16;
   localparam int WEIGHT_W  = 16;
   localparam int STATUS_W  = 3;
   localparam int KEY_W     = 10;
   localparam int TOTAL_W   = 13;
   localparam int PRODUCT_W = 32;

   // Upper bound applied to the raw key before the bin clamp.
   localparam logic [PRODUCT_W-1:0] KEY_CEILING = 32'd1048575;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_BEST   = 2'd2,
      OP_WORST  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE       = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_ZERO_COUNT = 3'd2,
      STAT_NOT_QUEUED = 3'd3,
      STAT_QUEUED     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_ADD_LINK,
      ST_ADD_PREV,
      ST_POP_HEAD,
      ST_POP_READ,
      ST_UNLINK,
      ST_UNLINK_SELF,
      ST_BEST_SCAN,
      ST_WORST_START,
      ST_WORST_SCAN,
      ST_DONE
   } state_type;

endpackage

FILE: sv/bpq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module bpq_ram #(
   parameter int Width = 13,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bpq_key.sv
// Markowitz key unit: registered (count-1)*(weight-1) product and clamp.
// Depends on bpq_pkg for field widths and the key ceiling.
module bpq_key #(
   parameter int BIN_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            start,
   input  logic [bpq_pkg::COUNT_W-1:0]     set_count,
   input  logic [bpq_pkg::WEIGHT_W-1:0]    lightest_weight,
   output logic [$clog2(BIN_COUNT)-1:0]    key
);

   localparam int BIW = $clog2(BIN_COUNT);
   localparam logic [bpq_pkg::PRODUCT_W-1:0] BinCap = bpq_pkg::PRODUCT_W'(BIN_COUNT - 1);
   localparam logic [bpq_pkg::PRODUCT_W-1:0] Cap =
      (BinCap < bpq_pkg::KEY_CEILING) ? BinCap : bpq_pkg::KEY_CEILING;

   logic [bpq_pkg::PRODUCT_W-1:0] prod_ff, prod_in;
   logic                          small_ff, small_in;
   logic                          wzero_ff, wzero_in;

   // One multiplier, registered before the clamp.
   assign prod_in  = bpq_pkg::PRODUCT_W'(set_count - 16'd1) *
                     bpq_pkg::PRODUCT_W'(lightest_weight - 16'd1);
   assign small_in = (set_count <= 16'd1);
   assign wzero_in = (lightest_weight == 16'd0);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= prod_in;
         small_ff <= small_in;
         wzero_ff <= wzero_in;
      end
   end

   // A zero weight saturates the weight term, so unless the count is at most one the key goes to the top bin.
   always_comb begin
      if (small_ff) begin
         key = '0;
      end else if (wzero_ff) begin
         key = BIW'(BIN_COUNT - 1);
      end else if (prod_ff > Cap) begin
         key = BIW'(Cap);
      end else begin
         key = BIW'(prod_ff);
      end
   end

endmodule

FILE: sv/markowitz_bucket_priority_queue_unit.sv
// Bucket priority queue of item ids kept as doubly linked lists in four link RAMs.
// Depends on bpq_pkg, bpq_ram and bpq_key.
//
// One request beat is handled at a time. Every removal rescans the best and worst
// bin markers one bin per cycle through the bin-head RAM read port. After reset a
// clearing pass initializes the link RAMs, and no request is taken until it ends.
// A finished response sits in an output register, so the next request is taken
// while it waits; that request then holds at its last cycle until the output
// register is free.
module markowitz_bucket_priority_queue_unit #(
   parameter int NUM_ITEMS = 4096,
   parameter int BIN_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic [bpq_pkg::ID_W-1:0]        req_item_id,
   input  logic [bpq_pkg::COUNT_W-1:0]     req_set_count,
   input  logic [bpq_pkg::WEIGHT_W-1:0]    req_lightest_weight,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bpq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bpq_pkg::ID_W-1:0]        rsp_result_id,
   output logic [bpq_pkg::KEY_W-1:0]       rsp_bin_key,
   output logic [bpq_pkg::TOTAL_W-1:0]     rsp_queued_total
);

   localparam int IW  = $clog2(NUM_ITEMS);
   localparam int BIW = $clog2(BIN_COUNT);
   localparam int LW  = $clog2(NUM_ITEMS + BIN_COUNT);
   localparam int BW  = $clog2(BIN_COUNT + 1);
   localparam int QW  = $clog2(NUM_ITEMS + 1);
   localparam int CLR = (NUM_ITEMS > BIN_COUNT) ? NUM_ITEMS : BIN_COUNT;
   localparam int CW  = $clog2(CLR);
   localparam logic [LW-1:0] ItemLimit = LW'(NUM_ITEMS);
   localparam logic [BW-1:0] BestEmpty = BW'(BIN_COUNT);

   // Link helpers: a link below NUM_ITEMS names an item, at or above it a bin head.
   function automatic logic is_item(input logic [LW-1:0] lnk);
      return lnk < ItemLimit;
   endfunction

   function automatic logic [BIW-1:0] head_index(input logic [LW-1:0] lnk);
      logic [LW-1:0] diff;
      diff = lnk - ItemLimit;
      return BIW'(diff);
   endfunction

   function automatic logic [LW-1:0] head_ref(input logic [BIW-1:0] bin);
      return ItemLimit + LW'(bin);
   endfunction

   // Sequencer and datapath registers.
   bpq_pkg::state_type      state_ff, state_in;
   bpq_pkg::op_type         op_ff, op_in;
   logic [bpq_pkg::ID_W-1:0] id_ff, id_in;
   logic                    zero_ff, zero_in;
   logic [LW-1:0]           tgt_ff, tgt_in;
   logic [LW-1:0]           nxt_ff, nxt_in;
   logic [LW-1:0]           prv_ff, prv_in;
   logic [BIW-1:0]          scan_ff, scan_in;
   logic [CW-1:0]           clr_ff, clr_in;
   logic [BW-1:0]           best_ff, best_in;
   logic [BIW-1:0]          worst_ff, worst_in;
   logic                    worst_none_ff, worst_none_in;
   logic [QW-1:0]           count_ff, count_in;
   bpq_pkg::status_type     status_ff, status_in;
   logic [bpq_pkg::ID_W-1:0] result_ff, result_in;
   logic [BIW-1:0]          keyrep_ff, keyrep_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   bpq_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [bpq_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [BIW-1:0]          rsp_key_ff, rsp_key_in;
   logic [QW-1:0]           rsp_total_ff, rsp_total_in;

   // RAM ports.
   logic            in_we, ip_we, hn_we, hp_we;
   logic [IW-1:0]   in_wa, ip_wa, item_ra;
   logic [BIW-1:0]  hn_wa, hp_wa, head_ra;
   logic [LW-1:0]   in_wd, ip_wd, hn_wd, hp_wd;
   logic [LW-1:0]   in_rd, ip_rd, hn_rd;
   logic [LW-1:0]   hp_rd;

   logic [BIW-1:0]  key;
   logic            accept;
   logic            id_in_range;
   logic            ready_out;
   logic [LW-1:0]   id_link;

   assign accept      = req_valid && req_ready;
   assign id_in_range = (32'(id_ff) < NUM_ITEMS);
   assign id_link     = LW'(id_ff);

   bpq_key #(.BIN_COUNT(BIN_COUNT)) u_key (
      .clock           (clock),
      .start           (accept),
      .set_count       (req_set_count),
      .lightest_weight (req_lightest_weight),
      .key             (key)
   );

   bpq_ram #(.Width(LW), .Depth(NUM_ITEMS)) u_item_next (
      .clock(clock), .wr_en(in_we), .wr_addr(in_wa), .wr_data(in_wd),
      .rd_addr(item_ra), .rd_data(in_rd)
   );

   bpq_ram #(.Width(LW), .Depth(NUM_ITEMS)) u_item_prev (
      .clock(clock), .wr_en(ip_we), .wr_addr(ip_wa), .wr_data(ip_wd),
      .rd_addr(item_ra), .rd_data(ip_rd)
   );

   bpq_ram #(.Width(LW), .Depth(BIN_COUNT)) u_head_next (
      .clock(clock), .wr_en(hn_we), .wr_addr(hn_wa), .wr_data(hn_wd),
      .rd_addr(head_ra), .rd_data(hn_rd)
   );

   // The head prev links are only ever written; the read port idles at bin 0.
   bpq_ram #(.Width(LW), .Depth(BIN_COUNT)) u_head_prev (
      .clock(clock), .wr_en(hp_we), .wr_addr(hp_wa), .wr_data(hp_wd),
      .rd_addr(BIW'(0)), .rd_data(hp_rd)
   );

   // Next state, RAM accesses and datapath updates.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      zero_in       = zero_ff;
      tgt_in        = tgt_ff;
      nxt_in        = nxt_ff;
      prv_in        = prv_ff;
      scan_in       = scan_ff;
      clr_in        = clr_ff;
      best_in       = best_ff;
      worst_in      = worst_ff;
      worst_none_in = worst_none_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      keyrep_in     = keyrep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_total_in  = rsp_total_ff;
      ready_out     = 1'b0;
      in_we = 1'b0; in_wa = '0; in_wd = '0;
      ip_we = 1'b0; ip_wa = '0; ip_wd = '0;
      hn_we = 1'b0; hn_wa = '0; hn_wd = '0;
      hp_we = 1'b0; hp_wa = '0; hp_wd = '0;
      item_ra = IW'(req_item_id);
      head_ra = key;

      unique case (state_ff)
         // Initialize every item and bin head to point at itself.
         bpq_pkg::ST_CLEAR: begin
            if (32'(clr_ff) < NUM_ITEMS) begin
               in_we = 1'b1; in_wa = IW'(clr_ff); in_wd = LW'(clr_ff);
               ip_we = 1'b1; ip_wa = IW'(clr_ff); ip_wd = LW'(clr_ff);
            end
            if (32'(clr_ff) < BIN_COUNT) begin
               hn_we = 1'b1; hn_wa = BIW'(clr_ff); hn_wd = head_ref(BIW'(clr_ff));
               hp_we = 1'b1; hp_wa = BIW'(clr_ff); hp_wd = head_ref(BIW'(clr_ff));
            end
            clr_in = clr_ff + CW'(1);
            if (32'(clr_ff) == CLR - 1) begin
               state_in = bpq_pkg::ST_IDLE;
            end
         end

         // Take a beat and read both links of its id.
         bpq_pkg::ST_IDLE: begin
            ready_out = 1'b1;
            if (req_valid) begin
               op_in     = bpq_pkg::op_type'(req_operation);
               id_in     = req_item_id;
               zero_in   = (req_set_count == '0);
               result_in = req_item_id;
               keyrep_in = '0;
               status_in = bpq_pkg::STAT_DONE;
               state_in  = bpq_pkg::ST_DECODE;
            end
         end

         bpq_pkg::ST_DECODE: begin
            case (op_ff)
               bpq_pkg::OP_ADD: begin
                  if (zero_ff) begin
                     status_in = bpq_pkg::STAT_ZERO_COUNT;
                     state_in  = bpq_pkg::ST_DONE;
                  end else begin
                     keyrep_in = key;
                     head_ra   = key;
                     if (!id_in_range) begin
                        status_in = bpq_pkg::STAT_NOT_QUEUED;
                        state_in  = bpq_pkg::ST_DONE;
                     end else if (in_rd != id_link) begin
                        status_in = bpq_pkg::STAT_QUEUED;
                        state_in  = bpq_pkg::ST_DONE;
                     end else begin
                        state_in = bpq_pkg::ST_ADD_LINK;
                     end
                  end
               end
               bpq_pkg::OP_REMOVE: begin
                  if (!id_in_range || in_rd == id_link) begin
                     status_in = bpq_pkg::STAT_NOT_QUEUED;
                     state_in  = bpq_pkg::ST_DONE;
                  end else begin
                     tgt_in   = id_link;
                     nxt_in   = in_rd;
                     prv_in   = ip_rd;
                     state_in = bpq_pkg::ST_UNLINK;
                  end
               end
               default: begin
                  // Best or worst: read the head of the marked bin.
                  if (op_ff == bpq_pkg::OP_BEST) begin
                     head_ra = BIW'(best_ff);
                     if (best_ff == BestEmpty) begin
                        status_in = bpq_pkg::STAT_EMPTY;
                        state_in  = bpq_pkg::ST_DONE;
                     end else begin
                        state_in = bpq_pkg::ST_POP_HEAD;
                     end
                  end else begin
                     head_ra = worst_ff;
                     if (worst_none_ff) begin
                        status_in = bpq_pkg::STAT_EMPTY;
                        state_in  = bpq_pkg::ST_DONE;
                     end else begin
                        state_in = bpq_pkg::ST_POP_HEAD;
                     end
                  end
               end
            endcase
         end

         // Link the id after the bin head; the old first entry points back to it.
         bpq_pkg::ST_ADD_LINK: begin
            in_we = 1'b1; in_wa = IW'(id_ff); in_wd = hn_rd;
            if (is_item(hn_rd)) begin
               ip_we = 1'b1; ip_wa = IW'(hn_rd); ip_wd = id_link;
            end else begin
               hp_we = 1'b1; hp_wa = head_index(hn_rd); hp_wd = id_link;
            end
            hn_we = 1'b1; hn_wa = keyrep_ff; hn_wd = id_link;
            state_in = bpq_pkg::ST_ADD_PREV;
         end

         bpq_pkg::ST_ADD_PREV: begin
            ip_we = 1'b1; ip_wa = IW'(id_ff); ip_wd = head_ref(keyrep_ff);
            count_in = count_ff + QW'(1);
            if (BW'(keyrep_ff) < best_ff) begin
               best_in = BW'(keyrep_ff);
            end
            if (worst_none_ff || keyrep_ff > worst_ff) begin
               worst_in      = keyrep_ff;
               worst_none_in = 1'b0;
            end
            state_in = bpq_pkg::ST_DONE;
         end

         // First entry of the marked bin; fetch its links.
         bpq_pkg::ST_POP_HEAD: begin
            item_ra = IW'(hn_rd);
            if (!is_item(hn_rd)) begin
               status_in = bpq_pkg::STAT_EMPTY;
               state_in  = bpq_pkg::ST_DONE;
            end else begin
               tgt_in    = hn_rd;
               result_in = bpq_pkg::ID_W'(hn_rd);
               state_in  = bpq_pkg::ST_POP_READ;
            end
         end

         bpq_pkg::ST_POP_READ: begin
            nxt_in   = in_rd;
            prv_in   = ip_rd;
            state_in = bpq_pkg::ST_UNLINK;
         end

         // Bridge the neighbors over the target.
         bpq_pkg::ST_UNLINK: begin
            if (is_item(nxt_ff)) begin
               ip_we = 1'b1; ip_wa = IW'(nxt_ff); ip_wd = prv_ff;
            end else begin
               hp_we = 1'b1; hp_wa = head_index(nxt_ff); hp_wd = prv_ff;
            end
            if (is_item(prv_ff)) begin
               in_we = 1'b1; in_wa = IW'(prv_ff); in_wd = nxt_ff;
            end else begin
               hn_we = 1'b1; hn_wa = head_index(prv_ff); hn_wd = nxt_ff;
            end
            state_in = bpq_pkg::ST_UNLINK_SELF;
         end

         // Mark the target unlinked and start the best marker rescan.
         bpq_pkg::ST_UNLINK_SELF: begin
            in_we = 1'b1; in_wa = IW'(tgt_ff); in_wd = tgt_ff;
            ip_we = 1'b1; ip_wa = IW'(tgt_ff); ip_wd = tgt_ff;
            count_in = count_ff - QW'(1);
            head_ra  = BIW'(best_ff);
            scan_in  = BIW'(best_ff);
            if (best_ff != BestEmpty) begin
               state_in = bpq_pkg::ST_BEST_SCAN;
            end else begin
               state_in = bpq_pkg::ST_WORST_START;
            end
         end

         // One bin per cycle upward until a nonempty one or the top bin.
         bpq_pkg::ST_BEST_SCAN: begin
            head_ra = scan_ff + BIW'(1);
            scan_in = scan_ff + BIW'(1);
            if (hn_rd != head_ref(scan_ff)) begin
               best_in  = BW'(scan_ff);
               state_in = bpq_pkg::ST_WORST_START;
            end else if (32'(scan_ff) == BIN_COUNT - 1) begin
               best_in  = BestEmpty;
               state_in = bpq_pkg::ST_WORST_START;
            end
         end

         bpq_pkg::ST_WORST_START: begin
            head_ra = worst_ff;
            scan_in = worst_ff;
            if (worst_none_ff) begin
               state_in = bpq_pkg::ST_DONE;
            end else begin
               state_in = bpq_pkg::ST_WORST_SCAN;
            end
         end

         // One bin per cycle downward until a nonempty one or bin zero.
         bpq_pkg::ST_WORST_SCAN: begin
            head_ra = scan_ff - BIW'(1);
            scan_in = scan_ff - BIW'(1);
            if (hn_rd != head_ref(scan_ff)) begin
               worst_in = scan_ff;
               state_in = bpq_pkg::ST_DONE;
            end else if (scan_ff == '0) begin
               worst_none_in = 1'b1;
               state_in      = bpq_pkg::ST_DONE;
            end
         end

         // Hand the result to the output register once it is free.
         bpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = result_ff;
               rsp_key_in    = keyrep_ff;
               rsp_total_in  = count_ff;
               state_in      = bpq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bpq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bpq_pkg::ST_CLEAR;
         clr_ff        <= '0;
         best_ff       <= BestEmpty;
         worst_ff      <= '0;
         worst_none_ff <= 1'b1;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         best_ff       <= best_in;
         worst_ff      <= worst_in;
         worst_none_ff <= worst_none_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      zero_ff       <= zero_in;
      tgt_ff        <= tgt_in;
      nxt_ff        <= nxt_in;
      prv_ff        <= prv_in;
      scan_ff       <= scan_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      keyrep_ff     <= keyrep_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_ready        = ready_out;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_bin_key      = bpq_pkg::KEY_W'(rsp_key_ff);
   assign rsp_queued_total = bpq_pkg::TOTAL_W'(rsp_total_ff);

   // Between operations both markers agree on whether the queue is empty.
   a_markers_agree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpq_pkg::ST_IDLE) |-> ((best_ff == BestEmpty) == worst_none_ff))
      else $error("best and worst markers disagree on emptiness");

   // Between operations an empty best marker means nothing is queued.
   a_count_markers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpq_pkg::ST_IDLE) |-> ((count_ff == '0) == (best_ff == BestEmpty)))
      else $error("queued count disagrees with best marker");

   // The queued count never exceeds the id space.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= NUM_ITEMS)
      else $error("queued count out of range");

endmodule
